// ===== rtl/fetp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fetp_pkg;

  // Count fields are 13 bits wide throughout
  typedef logic [12:0] cnt_t;

  // Double constants
  localparam logic [63:0] ONE_BITS = 64'h3FF0000000000000;
  localparam logic [63:0] EPS_BITS = 64'h3C9CD2B297D889BC;  // 1e-16
  localparam logic [63:0] NAN_BITS = 64'hFFF8000000000000;
  localparam logic [63:0] INF_BITS = 64'h7FF0000000000000;

  // Arithmetic unit operations: double times count, double over count, add, subtract
  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_DIV,
    FOP_ADD,
    FOP_SUB
  } fop_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TOTAL,
    REG_FLAGGED,
    REG_MODE
  } reg_e;

  // Arithmetic unit states
  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_ALIGN,
    F_ADD,
    F_NORM,
    F_ROUND,
    F_OUT
  } fstate_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_TP_START,
    S_TP_ISSUE,
    S_TP_WAIT,
    S_AFTER_TP,
    S_CMP_WAIT,
    S_ADD_ISSUE,
    S_ADD_WAIT,
    S_NEXT,
    S_DONE
  } sstate_e;

  // What the current table probability is for
  typedef enum logic [2:0] {
    PH_P0,
    PH_LOW,
    PH_HIGH,
    PH_UP,
    PH_MIN
  } phase_e;

  typedef struct packed {
    logic        valid;
    fop_e        op;
    logic [63:0] a;
    logic [63:0] b;
    cnt_t        k;
  } freq_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } frsp_t;

  typedef struct packed {
    cnt_t total;
    cnt_t flagged;
    logic mode;
  } cfg_t;

  // Significand with hidden bit
  function automatic logic [52:0] sig_of(logic [63:0] d);
    return {d[62:52] != 11'd0, d[51:0]};
  endfunction

  // Biased exponent, subnormals taken as exponent one
  function automatic logic signed [15:0] bexp_of(logic [63:0] d);
    return (d[62:52] == 11'd0) ? 16'sd1 : $signed({5'b0, d[62:52]});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fetp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fetp_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output fetp_pkg::cfg_t      cfg_o
);
  import fetp_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr;

  assign idx    = reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_TOTAL:   cfg_d.total   = pwdata[12:0];
        REG_FLAGGED: cfg_d.flagged = pwdata[12:0];
        REG_MODE:    cfg_d.mode    = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total   <= 13'd1;
      cfg_q.flagged <= 13'd1;
      cfg_q.mode    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_TOTAL:   prdata = {19'b0, cfg_q.total};
      REG_FLAGGED: prdata = {19'b0, cfg_q.flagged};
      REG_MODE:    prdata = {31'b0, cfg_q.mode};
      default:     prdata = 32'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/fetp_fpu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fetp_fpu (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fetp_pkg::freq_t req_i,
  output fetp_pkg::frsp_t      rsp_o
);
  import fetp_pkg::*;

  // Working value is m / 2^79 * 2^(be - 1023), sticky below bit 0
  fstate_e            state_q, state_d;
  logic [79:0]        m_q, m_d, sm_q, sm_d;
  logic signed [15:0] be_q, be_d;
  logic               sign_q, sign_d, st_q, st_d, sub_q, sub_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [12:0]        rem_q, rem_d, k_q, k_d;
  logic [63:0]        res_q, res_d;

  logic [52:0]        sig_a, sig_b, sig_big, sig_sml;
  logic signed [15:0] be_a, be_b, be_big, be_sml, diff;
  logic               a_inf, b_inf, swap;
  logic [65:0]        prod;
  logic [13:0]        r2;
  logic               ge;
  logic [80:0]        r81;
  logic [52:0]        mant, mant2;
  logic [53:0]        sum54;
  logic               grd, stk, inc;
  logic signed [15:0] be2;

  assign sig_a   = sig_of(req_i.a);
  assign sig_b   = sig_of(req_i.b);
  assign be_a    = bexp_of(req_i.a);
  assign be_b    = bexp_of(req_i.b);
  assign a_inf   = req_i.a[62:52] == 11'h7FF;
  assign b_inf   = req_i.b[62:52] == 11'h7FF;
  assign swap    = req_i.b[62:0] > req_i.a[62:0];
  assign sig_big = swap ? sig_b : sig_a;
  assign sig_sml = swap ? sig_a : sig_b;
  assign be_big  = swap ? be_b : be_a;
  assign be_sml  = swap ? be_a : be_b;
  assign diff    = be_big - be_sml;

  assign prod = m_q[52:0] * k_q;
  assign r2   = {rem_q, sm_q[79]};
  assign ge   = r2 >= {1'b0, k_q};
  assign r81  = sub_q ? ({1'b0, m_q} - {1'b0, sm_q}) : ({1'b0, m_q} + {1'b0, sm_q});

  // Round to nearest even on the top 53 bits
  assign mant  = m_q[79:27];
  assign grd   = m_q[26];
  assign stk   = (|m_q[25:0]) | st_q;
  assign inc   = grd & (stk | mant[0]);
  assign sum54 = {1'b0, mant} + {53'b0, inc};
  assign mant2 = sum54[53] ? sum54[53:1] : sum54[52:0];
  assign be2   = be_q + (sum54[53] ? 16'sd1 : 16'sd0);

  assign rsp_o.done = state_q == F_OUT;
  assign rsp_o.res  = res_q;

  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    sm_d    = sm_q;
    be_d    = be_q;
    sign_d  = sign_q;
    st_d    = st_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    k_d     = k_q;
    res_d   = res_q;
    case (state_q)
      // Unpack operands and pick the path
      F_IDLE: begin
        if (req_i.valid) begin
          sign_d = 1'b0;
          st_d   = 1'b0;
          k_d    = req_i.k;
          case (req_i.op)
            FOP_MUL: begin
              if (a_inf) begin
                res_d   = req_i.a;
                state_d = F_OUT;
              end else begin
                m_d     = {27'b0, sig_a};
                be_d    = be_a + 16'sd13;
                state_d = F_MUL;
              end
            end
            FOP_DIV: begin
              if (a_inf) begin
                res_d   = req_i.a;
                state_d = F_OUT;
              end else begin
                sm_d    = {sig_a, 27'b0};
                m_d     = 80'b0;
                rem_d   = 13'b0;
                cnt_d   = 7'd80;
                be_d    = be_a;
                state_d = F_DIV;
              end
            end
            default: begin
              sub_d = req_i.op == FOP_SUB;
              if (a_inf || b_inf) begin
                if ((req_i.op == FOP_SUB) && a_inf && b_inf) begin
                  res_d = NAN_BITS;
                end else if ((req_i.op == FOP_SUB) && b_inf) begin
                  res_d = {1'b1, INF_BITS[62:0]};
                end else begin
                  res_d = INF_BITS;
                end
                state_d = F_OUT;
              end else begin
                m_d     = {sig_big, 27'b0};
                sm_d    = {sig_sml, 27'b0};
                cnt_d   = (diff > 16'sd81) ? 7'd81 : diff[6:0];
                be_d    = be_big;
                sign_d  = (req_i.op == FOP_SUB) && swap;
                state_d = F_ALIGN;
              end
            end
          endcase
        end
      end
      // Scale significand by the count
      F_MUL: begin
        m_d     = {prod, 14'b0};
        state_d = F_NORM;
      end
      // One quotient bit per cycle
      F_DIV: begin
        rem_d = ge ? 13'(r2 - {1'b0, k_q}) : r2[12:0];
        m_d   = {m_q[78:0], ge};
        sm_d  = {sm_q[78:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          st_d    = rem_d != 13'b0;
          state_d = F_NORM;
        end
      end
      // Shift smaller operand right, jam lost bits into bit 0
      F_ALIGN: begin
        if (cnt_q == 7'd0) begin
          state_d = F_ADD;
        end else begin
          sm_d  = {1'b0, sm_q[79:1]} | {79'b0, sm_q[0]};
          cnt_d = cnt_q - 7'd1;
        end
      end
      F_ADD: begin
        if (r81[80]) begin
          m_d  = r81[80:1] | {79'b0, r81[0]};
          be_d = be_q + 16'sd1;
        end else begin
          m_d = r81[79:0];
        end
        state_d = F_NORM;
      end
      // Normalize one bit per cycle, denormalize below the minimum exponent
      F_NORM: begin
        if ((m_q == 80'b0) && !st_q) begin
          res_d   = 64'b0;
          state_d = F_OUT;
        end else if (be_q < 16'sd1) begin
          m_d  = {1'b0, m_q[79:1]};
          st_d = st_q | m_q[0];
          be_d = be_q + 16'sd1;
        end else if (!m_q[79] && (be_q > 16'sd1)) begin
          m_d  = {m_q[78:0], 1'b0};
          be_d = be_q - 16'sd1;
        end else begin
          state_d = F_ROUND;
        end
      end
      // Round and pack
      F_ROUND: begin
        if (be2 >= 16'sd2047) begin
          res_d = {sign_q, INF_BITS[62:0]};
        end else begin
          res_d = {sign_q, (mant2[52] ? be2[10:0] : 11'd0), mant2[51:0]};
        end
        state_d = F_OUT;
      end
      F_OUT: state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    sm_q   <= sm_d;
    be_q   <= be_d;
    sign_q <= sign_d;
    st_q   <= st_d;
    sub_q  <= sub_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/fisher_exact_test_pvalue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+------------------------------
// request   | func_i, support_count_i, hit_count_i          | start high, busy low
// result    | p_value_bits_o, score_o, range_error_o        | done_o, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready always high
//
// One transaction runs on one shared double unit (multiply or divide by a count,
// add, subtract) under the sequencer below. A table probability costs 4*x unit
// operations. A request sums up to min(x, n1) + 1 tables; each hit count beyond
// the support adds an empty table; a minimum request takes one table.
// Reset clears control and the registers to total 1, flagged 1, two-sided.
// busy stays high until the result strobe; the receiver cannot stall.

module fisher_exact_test_pvalue_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func_i,
  input  wire logic [12:0] support_count_i,
  input  wire logic [12:0] hit_count_i,
  output logic             done_o,
  output logic [63:0]      p_value_bits_o,
  output logic [12:0]      score_o,
  output logic             range_error_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fetp_pkg::*;

  cfg_t        cfg;
  freq_t       freq;
  frsp_t       frsp;

  sstate_e     state_q, state_d;
  phase_e      ph_q, ph_d;
  cnt_t        x_q, x_d, hit_q, hit_d, i_q, i_d;
  logic [13:0] k_q, k_d;
  logic        func_q, func_d, err_q, err_d, seg_q, seg_d;
  logic [1:0]  op_q, op_d;
  logic [63:0] p_q, p_d, p0_q, p0_d, pk_q, pk_d;

  cnt_t        n, n1, n0, top, b13, k13, limit, opnd;
  logic [13:0] bdiff;
  logic        invalid, gt, res_nan;

  fetp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  fetp_fpu u_fpu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (freq),
    .rsp_o (frsp)
  );

  // Group sizes, flagged saturated to total
  assign n   = cfg.total;
  assign n1  = (cfg.flagged > cfg.total) ? cfg.total : cfg.flagged;
  assign n0  = n - n1;
  assign top = (x_q < n1) ? x_q : n1;

  // Current table (x, k)
  assign k13     = k_q[12:0];
  assign bdiff   = {1'b0, x_q} - k_q;
  assign b13     = bdiff[12:0];
  assign invalid = (k_q > {1'b0, x_q}) || (k_q > {1'b0, n1}) || (b13 > n0) || (x_q > n);
  assign limit   = seg_q ? b13 : k13;

  // Count operand of the next product step
  always_comb begin
    case ({seg_q, op_q})
      3'b000:  opnd = n1 - i_q;
      3'b001:  opnd = k13 - i_q;
      3'b010:  opnd = x_q - i_q;
      3'b011:  opnd = n - i_q;
      3'b100:  opnd = n0 - i_q;
      3'b101:  opnd = b13 - i_q;
      3'b110:  opnd = b13 - i_q;
      default: opnd = n - k13 - i_q;
    endcase
  end

  // Difference exceeds 1e-16
  assign res_nan = (frsp.res[62:52] == 11'h7FF) && (frsp.res[51:0] != 52'b0);
  assign gt      = !frsp.res[63] && !res_nan && (frsp.res[62:0] > EPS_BITS[62:0]);

  assign busy           = state_q != S_IDLE;
  assign done_o         = state_q == S_DONE;
  assign p_value_bits_o = p_q;
  assign score_o        = func_q ? 13'b0 : hit_q;
  assign range_error_o  = err_q;

  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    x_d        = x_q;
    hit_d      = hit_q;
    i_d        = i_q;
    k_d        = k_q;
    func_d     = func_q;
    err_d      = err_q;
    seg_d      = seg_q;
    op_d       = op_q;
    p_d        = p_q;
    p0_d       = p0_q;
    pk_d       = pk_q;
    freq.valid = 1'b0;
    freq.op    = (op_q[0]) ? FOP_DIV : FOP_MUL;
    freq.a     = pk_q;
    freq.b     = p0_q;
    freq.k     = opnd;
    case (state_q)
      // Take a transaction
      S_IDLE: begin
        if (start) begin
          x_d    = support_count_i;
          hit_d  = hit_count_i;
          func_d = func_i;
          err_d  = 1'b0;
          if (func_i) begin
            ph_d = PH_MIN;
            if (support_count_i <= n1) begin
              k_d     = {1'b0, support_count_i};
              state_d = S_TP_START;
            end else if (support_count_i <= n0) begin
              k_d     = {1'b0, n1};
              state_d = S_TP_START;
            end else begin
              err_d   = 1'b1;
              p_d     = 64'b0;
              state_d = S_DONE;
            end
          end else begin
            ph_d    = PH_P0;
            k_d     = {1'b0, hit_count_i};
            state_d = S_TP_START;
          end
        end
      end
      // Start a table probability
      S_TP_START: begin
        if (invalid) begin
          pk_d    = 64'b0;
          state_d = S_AFTER_TP;
        end else begin
          pk_d    = ONE_BITS;
          i_d     = 13'b0;
          seg_d   = 1'b0;
          op_d    = 2'd0;
          state_d = S_TP_ISSUE;
        end
      end
      // Issue the next product step or close the loop
      S_TP_ISSUE: begin
        if (i_q == limit) begin
          if (!seg_q) begin
            seg_d = 1'b1;
            i_d   = 13'b0;
          end else begin
            state_d = S_AFTER_TP;
          end
        end else begin
          freq.valid = 1'b1;
          state_d    = S_TP_WAIT;
        end
      end
      S_TP_WAIT: begin
        if (frsp.done) begin
          pk_d = frsp.res;
          op_d = op_q + 2'd1;
          if (op_q == 2'd3) begin
            i_d = i_q + 13'd1;
          end
          state_d = S_TP_ISSUE;
        end
      end
      // Use the finished probability
      S_AFTER_TP: begin
        case (ph_q)
          PH_P0: begin
            p0_d = pk_q;
            p_d  = pk_q;
            if (cfg.mode) begin
              k_d  = {1'b0, hit_q} + 14'd1;
              ph_d = PH_UP;
            end else begin
              k_d  = 14'd0;
              ph_d = PH_LOW;
            end
            state_d = S_NEXT;
          end
          PH_MIN: begin
            p_d     = pk_q;
            state_d = S_DONE;
          end
          PH_UP: state_d = S_ADD_ISSUE;
          default: begin
            freq.valid = 1'b1;
            freq.op    = FOP_SUB;
            freq.a     = pk_q;
            freq.b     = p0_q;
            state_d    = S_CMP_WAIT;
          end
        endcase
      end
      // Stop a tail walk once a table is clearly more likely
      S_CMP_WAIT: begin
        if (frsp.done) begin
          if (gt) begin
            if (ph_q == PH_LOW) begin
              k_d     = {1'b0, top};
              ph_d    = PH_HIGH;
              state_d = S_NEXT;
            end else begin
              state_d = S_DONE;
            end
          end else begin
            state_d = S_ADD_ISSUE;
          end
        end
      end
      S_ADD_ISSUE: begin
        freq.valid = 1'b1;
        freq.op    = FOP_ADD;
        freq.a     = p_q;
        freq.b     = pk_q;
        state_d    = S_ADD_WAIT;
      end
      // Accumulate and step k
      S_ADD_WAIT: begin
        if (frsp.done) begin
          p_d     = frsp.res;
          k_d     = (ph_q == PH_HIGH) ? (k_q - 14'd1) : (k_q + 14'd1);
          state_d = S_NEXT;
        end
      end
      // Pick the next table or finish
      S_NEXT: begin
        case (ph_q)
          PH_LOW: begin
            if (k_q < {1'b0, hit_q}) begin
              state_d = S_TP_START;
            end else begin
              k_d  = {1'b0, top};
              ph_d = PH_HIGH;
            end
          end
          PH_HIGH: state_d = (k_q > {1'b0, hit_q}) ? S_TP_START : S_DONE;
          PH_UP:   state_d = (k_q <= {1'b0, top}) ? S_TP_START : S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q   <= ph_d;
    x_q    <= x_d;
    hit_q  <= hit_d;
    i_q    <= i_d;
    k_q    <= k_d;
    func_q <= func_d;
    err_q  <= err_d;
    seg_q  <= seg_d;
    op_q   <= op_d;
    p_q    <= p_d;
    p0_q   <= p0_d;
    pk_q   <= pk_d;
  end

endmodule

`default_nettype wire

// ===== rtl/fetp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fetp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [63:0] p_value_bits_o,
  input wire logic [12:0] score_o,
  input wire logic        range_error_o
);

  // An accepted transaction makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("unit not busy after accepting a transaction");

  // A result appears only while busy and releases the unit
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 !busy)
    else $error("result strobe outside a busy period");

  // A range error carries a zero probability and no score
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && range_error_o |-> (p_value_bits_o == 64'b0) && (score_o == 13'b0))
    else $error("range error with nonzero payload");

  // Probabilities are never negative
  a_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !p_value_bits_o[63])
    else $error("negative probability");

endmodule

bind fisher_exact_test_pvalue_unit fetp_checker u_fetp_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fetp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [12:0] support_count_i;
  logic [12:0] hit_count_i;
  logic        done_o;
  logic [63:0] p_value_bits_o;
  logic [12:0] score_o;
  logic        range_error_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fisher_exact_test_pvalue_unit DUT (.*);

  typedef struct {
    logic [63:0] p_bits;
    cnt_t        score;
    logic        err;
  } pv_rec_t;

  typedef struct {
    int unsigned n;
    int unsigned n1;
    bit          mode;
    bit          func;
    int unsigned x;
    int unsigned a;
    bit          known;
    logic [63:0] p_bits;
    int unsigned score;
    bit          err;
  } pv_row_t;

  pv_rec_t     pv_expect_q[$];
  cnt_t        cfg_total;
  cnt_t        cfg_flagged;
  logic        cfg_mode;
  int unsigned mismatch_cnt;
  int unsigned result_cnt;
  int unsigned item_cnt;
  int unsigned range_err_cnt;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit
  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  // Probability of one table, same operation order as the block
  function automatic real table_prob(int x, int a);
    int  n, n1, n0, b;
    real p, used;
    n  = cfg_total;
    n1 = (cfg_flagged > cfg_total) ? cfg_total : cfg_flagged;
    n0 = n - n1;
    b  = x - a;
    p  = 1.0;
    if (a < 0 || b < 0 || a > n1 || b > n0 || x > n) return 0.0;
    for (int i = 0; i < a; i++) begin
      p = p * real'(n1 - i) / real'(a - i);
      p = p * real'(x - i) / real'(n - i);
    end
    for (int i = 0; i < b; i++) begin
      used = real'(a + i);
      p = p * real'(n0 - i) / real'(b - i);
      p = p * (real'(x) - used) / (real'(n) - used);
    end
    return p;
  endfunction

  // Expected result of one request
  function automatic pv_rec_t predict_pvalue(bit func, int x, int a);
    pv_rec_t r;
    int  n1, n0, top;
    real p0, p, pk;
    n1 = (cfg_flagged > cfg_total) ? cfg_total : cfg_flagged;
    n0 = int'(cfg_total) - n1;
    r.err = 1'b0;
    r.score = '0;
    if (!func) begin
      top = (x < n1) ? x : n1;
      p0 = table_prob(x, a);
      p = p0;
      if (!cfg_mode) begin
        for (int k = 0; k < a; k++) begin
          pk = table_prob(x, k);
          if (1.0e-16 < pk - p0) break;
          p = p + pk;
        end
        for (int k = top; a < k; k--) begin
          pk = table_prob(x, k);
          if (1.0e-16 < pk - p0) break;
          p = p + pk;
        end
      end else begin
        for (int k = a + 1; k <= top; k++) p = p + table_prob(x, k);
      end
      r.p_bits = $realtobits(p);
      r.score = cnt_t'(a);
    end else if (x <= n1) begin
      r.p_bits = $realtobits(table_prob(x, x));
    end else if (x <= n0) begin
      r.p_bits = $realtobits(table_prob(x, n1));
    end else begin
      r.p_bits = '0;
      r.err = 1'b1;
    end
    return r;
  endfunction

  // Write one register over APB
  task automatic apb_write(reg_e idx, int unsigned val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TOTAL:   cfg_total = cnt_t'(val);
      REG_FLAGGED: cfg_flagged = cnt_t'(val);
      default:     cfg_mode = val[0];
    endcase
  endtask

  // Wait out pending results, then load a new setting
  task automatic set_config(int unsigned n, int unsigned n1, bit mode);
    while (pv_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    apb_write(REG_TOTAL, n);
    apb_write(REG_FLAGGED, n1);
    apb_write(REG_MODE, mode);
  endtask

  // Issue one request and hold it until the block takes it
  task automatic send_request(int gap, bit func, int x, int a, bit known, pv_rec_t kexp);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    func_i          <= func;
    support_count_i <= 13'(x);
    hit_count_i     <= 13'(a);
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    pv_expect_q.push_back(known ? kexp : predict_pvalue(func, x, a));
    item_cnt++;
  endtask

  // Check each result against the oldest expectation
  always @(negedge clk_i) begin
    pv_rec_t e;
    if (rst_ni && done_o) begin
      result_cnt++;
      if (range_error_o) range_err_cnt++;
      if (pv_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result p=%h", p_value_bits_o);
      end else begin
        e = pv_expect_q.pop_front();
        if (p_value_bits_o !== e.p_bits || score_o !== e.score
            || range_error_o !== e.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp p=%h score=%0d err=%b, got p=%h score=%0d err=%b",
                     e.p_bits, e.score, e.err, p_value_bits_o, score_o, range_error_o);
        end
      end
    end
  end

  pv_row_t directed_tbl[] = '{
    '{1, 1, 0, 1, 0, 0, 1, 64'h3FF0000000000000, 0, 0},
    '{1, 1, 0, 1, 8191, 0, 1, 64'h0, 0, 1},
    '{1, 1, 0, 0, 1, 1, 1, 64'h3FF0000000000000, 1, 0},
    '{1, 1, 0, 0, 1, 8191, 0, 0, 0, 0},
    '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{10, 4, 0, 0, 5, 2, 0, 0, 0, 0},
    '{10, 4, 0, 0, 5, 0, 0, 0, 0, 0},
    '{10, 4, 0, 0, 5, 4, 0, 0, 0, 0},
    '{10, 4, 0, 0, 5, 5, 0, 0, 0, 0},
    '{10, 4, 0, 1, 3, 0, 0, 0, 0, 0},
    '{10, 4, 0, 1, 6, 0, 0, 0, 0, 0},
    '{10, 4, 0, 1, 7, 0, 1, 64'h0, 0, 1},
    '{10, 4, 1, 0, 5, 2, 0, 0, 0, 0},
    '{10, 4, 1, 0, 5, 0, 0, 0, 0, 0},
    '{10, 4, 1, 0, 5, 4, 0, 0, 0, 0},
    '{10, 4, 1, 0, 11, 0, 0, 0, 0, 0},
    '{6, 9, 0, 0, 4, 2, 0, 0, 0, 0},
    '{6, 9, 1, 1, 4, 0, 0, 0, 0, 0},
    '{4096, 4096, 1, 0, 3, 3, 0, 0, 0, 0},
    '{4096, 1, 0, 0, 4, 1, 0, 0, 0, 0},
    '{4096, 1, 0, 1, 8, 0, 0, 0, 0, 0},
    '{4096, 2048, 0, 0, 6, 3, 0, 0, 0, 0}
  };

  int unsigned rnd_n[]  = '{1, 8, 8, 4096, 13, 20, 5};
  int unsigned rnd_n1[] = '{1, 3, 3, 7, 13, 10, 8191};
  bit          rnd_md[] = '{1, 0, 1, 1, 0, 0, 1};

  initial begin
    pv_rec_t kexp;
    int      gap, x, a, xmax;
    bit      func;
    start = 1'b0; func_i = 1'b0; support_count_i = '0; hit_count_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_total = 13'd1; cfg_flagged = 13'd1; cfg_mode = 1'b0;
    mismatch_cnt = 0; result_cnt = 0; item_cnt = 0; range_err_cnt = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, starting from the reset setting
    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].n != cfg_total || directed_tbl[i].n1 != cfg_flagged
          || directed_tbl[i].mode != cfg_mode) begin
        start <= 1'b0;
        set_config(directed_tbl[i].n, directed_tbl[i].n1, directed_tbl[i].mode);
      end
      kexp.p_bits = directed_tbl[i].p_bits;
      kexp.score  = cnt_t'(directed_tbl[i].score);
      kexp.err    = directed_tbl[i].err;
      send_request($urandom_range(0, 12), directed_tbl[i].func,
                   directed_tbl[i].x, directed_tbl[i].a, directed_tbl[i].known, kexp);
    end

    // Random phases, small tables mostly, noise on full field range
    foreach (rnd_n[p]) begin
      start <= 1'b0;
      set_config(rnd_n[p], rnd_n1[p], rnd_md[p]);
      for (int j = 0; j < 15; j++) begin
        gap  = $urandom_range(0, 12);
        func = $urandom_range(0, 1);
        xmax = (rnd_n[p] < 10) ? rnd_n[p] : 10;
        if (rnd_n[p] < 32 && $urandom_range(0, 4) == 0) begin
          x = $urandom_range(0, 8191);
          a = $urandom_range(0, 3);
        end else begin
          x = $urandom_range(0, xmax);
          a = ($urandom_range(0, 5) == 0) ? x + 1 : $urandom_range(0, x);
        end
        send_request(gap, func, x, a, 1'b0, kexp);
      end
    end
    start <= 1'b0;

    // Drain
    while (pv_expect_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Ran %0d requests: %0d directed rows, then %0d random settings.",
             item_cnt, directed_tbl.size(), rnd_n.size());
    $display("Saw %0d results, %0d of them range errors.", result_cnt, range_err_cnt);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
